>>> sv/rhpm_pkg.sv
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared constants, types and the modulo-1011 reduction for the rolling hash
// pattern matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

    // Default pattern capacity of the window.
    localparam int PATTERN_MAX_DEF = 16;

    // Hash arithmetic: radix 128, modulus 1011.
    localparam int HASH_RADIX = 128;
    localparam int HASH_MOD   = 1011;
    localparam int RADIX_SH   = $clog2(HASH_RADIX);
    localparam int HASH_W     = 10;
    // 2^10 folds to this value modulo 1011.
    localparam int REDUCE_K   = (1 << HASH_W) - HASH_MOD;
    // Width of the pre-reduction sum: hash*128 + byte + stored product.
    localparam int SUM_W      = 19;
    // Width of a byte times a hash residue.
    localparam int PROD_W     = 18;

    // Negated radix power for a one-byte pattern: -(128^1) mod 1011.
    localparam logic [HASH_W-1:0] RESET_QFAC = HASH_W'(HASH_MOD - HASH_RADIX);

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int PAT_BYTES  = 16;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_LENGTH     = 2'd0,
        REG_BYTES_LOW  = 2'd1,
        REG_BYTES_HIGH = 2'd2
    } reg_index_t;

    // One classified text byte, passed from front to back.
    typedef struct packed {
        logic        found;
        logic [31:0] start;
        logic        done;
    } rhpm_entry_t;

    // Pattern-side status handed from the configuration unit to the front.
    typedef struct packed {
        logic              busy;
        logic              restart;
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] qfac;
    } rhpm_pat_t;

    // Reduce a sum below 2^19 modulo 1011 by folding the upper bits twice.
    function automatic logic [HASH_W-1:0] hash_reduce(input logic [SUM_W-1:0] x);
        logic [12:0] s1;
        logic [10:0] s2;
        logic [10:0] r;
        s1 = 13'(x[SUM_W-1:HASH_W]) * 13'(REDUCE_K) + 13'(x[HASH_W-1:0]);
        s2 = 11'(s1[12:HASH_W]) * 11'(REDUCE_K) + 11'(s1[HASH_W-1:0]);
        r  = (s2 >= 11'(HASH_MOD)) ? (s2 - 11'(HASH_MOD)) : s2;
        return r[HASH_W-1:0];
    endfunction

endpackage

>>> sv/rolling_hash_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher_core: streaming Rabin-Karp byte matcher.
// A result passes through the queue and then the output register.
// Throughput 1 byte per cycle unless the queue is full; a register write stalls
// input while the pattern is rederived for the clamped length (1..PATTERN_MAX).
// Reset loads length 1 and zero pattern bytes; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher_core #(
    parameter int PATTERN_MAX = rhpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       text_byte,
    input  logic                             end_of_text,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             match_found,
    output logic [31:0]                      match_start,
    output logic [31:0]                      total_matches,
    output logic                             text_done,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rhpm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rhpm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rhpm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import rhpm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic [LW-1:0]               eff_len;
    logic [PATTERN_MAX-1:0][7:0] aligned_pat;
    rhpm_pat_t                   pat_info;
    logic                        push;
    rhpm_entry_t                 push_entry;
    logic                        q_full;
    logic                        pop;
    logic                        head_valid;
    rhpm_entry_t                 head_entry;

    // Registers and pattern derivation.
    rhpm_cfg #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .eff_len    (eff_len),
        .aligned_pat(aligned_pat),
        .pat_info   (pat_info)
    );

    // Window, hash and classification.
    rhpm_front #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .eff_len    (eff_len),
        .aligned_pat(aligned_pat),
        .pat_info   (pat_info),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    rhpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (q_full),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    // Counting and output register.
    rhpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (pat_info.restart),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_found  (match_found),
        .match_start  (match_start),
        .total_matches(total_matches),
        .text_done    (text_done)
    );

    // No request may enter while the pattern is being rederived.
    assert property (@(posedge clk) disable iff (!rst_n)
        pat_info.busy |-> !(in_valid && !in_stall))
        else $error("request accepted during pattern derivation");

    // A reported match always has a nonzero running total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && match_found) |-> (total_matches != 32'd0))
        else $error("match reported with zero total");

    // A result without a match carries a zero start position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !match_found) |-> (match_start == 32'd0))
        else $error("nonzero start without a match");

    // The queue is never pushed while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("queue overflow");

endmodule

>>> sv/rhpm_cfg.sv
// ----------------------------------------------------------------------------
// rhpm_cfg
// Configuration registers and the sequential unit that derives the pattern
// hash, the negated radix power and the aligned pattern after each write.
// ----------------------------------------------------------------------------
module rhpm_cfg #(
    parameter int PATTERN_MAX = rhpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rhpm_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [rhpm_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [rhpm_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [$clog2(PATTERN_MAX+1)-1:0]     eff_len,
    output logic [PATTERN_MAX-1:0][7:0]          aligned_pat,
    output rhpm_pkg::rhpm_pat_t                  pat_info
);
    import rhpm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int SW = (LW > 5) ? LW : 5;

    logic [LEN_W-1:0]           len_reg;
    logic [CFG_DATA_W-1:0]      low_reg;
    logic [CFG_DATA_W-1:0]      high_reg;
    logic                       busy_reg;
    logic [LW-1:0]              step_reg;
    logic [HASH_W-1:0]          ph_reg;
    logic [HASH_W-1:0]          pw_reg;
    logic [HASH_W-1:0]          qfac_reg;
    logic [PATTERN_MAX-1:0][7:0] aligned_reg;
    logic [PATTERN_MAX-1:0][7:0] aligned_next;

    reg_index_t                 reg_sel;
    logic                       wr_en;
    logic                       cfg_write;
    logic [2*CFG_DATA_W-1:0]    pat_flat;
    logic [7:0]                 pat_arr [PAT_BYTES];
    logic [SW-1:0]              step_ext;
    logic [7:0]                 step_byte;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;

    // Only writes to a known register restart the text and rederive.
    assign cfg_write = wr_en && ((reg_sel == REG_LENGTH) || (reg_sel == REG_BYTES_LOW) ||
                                 (reg_sel == REG_BYTES_HIGH));

    // Clamp the configured length into 1..PATTERN_MAX.
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (32'(len_reg) > 32'(PATTERN_MAX))
        begin
            eff_len = LW'(PATTERN_MAX);
        end
        else
        begin
            eff_len = LW'(len_reg);
        end
    end

    // Pattern bytes as an array.
    assign pat_flat = {high_reg, low_reg};
    always_comb
    begin
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pat_arr[i] = pat_flat[8*i +: 8];
        end
    end

    // Byte consumed by the current hash step; bytes past the register range are zero.
    assign step_ext  = SW'(step_reg);
    assign step_byte = (step_ext < SW'(PAT_BYTES)) ? pat_arr[step_ext[3:0]] : 8'h00;

    // Pattern reversed so that entry j lines up with window tap j.
    always_comb
    begin
        logic [SW-1:0] idx;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            idx = SW'(eff_len) - SW'(1) - SW'(j);
            if ((SW'(j) < SW'(eff_len)) && (idx < SW'(PAT_BYTES)))
            begin
                aligned_next[j] = pat_arr[idx[3:0]];
            end
            else
            begin
                aligned_next[j] = 8'h00;
            end
        end
    end

    // Registers and the derivation sequencer, one hash step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_W'(1);
            low_reg     <= '0;
            high_reg    <= '0;
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            ph_reg      <= '0;
            pw_reg      <= HASH_W'(1);
            qfac_reg    <= RESET_QFAC;
            aligned_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_LENGTH:     len_reg  <= pwdata[LEN_W-1:0];
                REG_BYTES_LOW:  low_reg  <= pwdata;
                REG_BYTES_HIGH: high_reg <= pwdata;
                default:        ;
            endcase
            busy_reg <= 1'b1;
            step_reg <= '0;
            ph_reg   <= '0;
            pw_reg   <= HASH_W'(1);
        end
        else if (busy_reg)
        begin
            aligned_reg <= aligned_next;
            if (step_reg < eff_len)
            begin
                ph_reg   <= hash_reduce(SUM_W'({ph_reg, {RADIX_SH{1'b0}}}) + SUM_W'(step_byte));
                pw_reg   <= hash_reduce(SUM_W'({pw_reg, {RADIX_SH{1'b0}}}));
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
                qfac_reg <= (pw_reg == '0) ? '0 : (HASH_W'(HASH_MOD) - pw_reg);
            end
        end
    end

    // Read data.
    always_comb
    begin
        case (reg_sel)
            REG_LENGTH:     prdata = CFG_DATA_W'(len_reg);
            REG_BYTES_LOW:  prdata = low_reg;
            REG_BYTES_HIGH: prdata = high_reg;
            default:        prdata = '0;
        endcase
    end

    assign aligned_pat      = aligned_reg;
    assign pat_info.busy    = busy_reg;
    assign pat_info.restart = cfg_write;
    assign pat_info.hash    = ph_reg;
    assign pat_info.qfac    = qfac_reg;

endmodule

>>> sv/rhpm_front.sv
// ----------------------------------------------------------------------------
// rhpm_front
// Accepts text bytes, shifts the window, rolls the hash and classifies each
// byte as a match or not before handing it to the queue.
// ----------------------------------------------------------------------------
module rhpm_front #(
    parameter int PATTERN_MAX = rhpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        text_byte,
    input  logic                              end_of_text,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]  eff_len,
    input  logic [PATTERN_MAX-1:0][7:0]       aligned_pat,
    input  rhpm_pkg::rhpm_pat_t               pat_info,
    input  logic                              q_full,
    output logic                              push,
    output rhpm_pkg::rhpm_entry_t             push_entry
);
    import rhpm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]        window_reg [PATTERN_MAX];
    logic [PROD_W-1:0] prod_reg   [PATTERN_MAX];
    logic [LW-1:0]     fill_reg;
    logic [LW-1:0]     fill_next;
    logic [31:0]       pos_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    logic [7:0]        window_new [PATTERN_MAX];
    logic              accept;
    logic              full_now;
    logic [IW-1:0]     tail_idx;
    logic [PROD_W-1:0] drop;
    logic [SUM_W-1:0]  hash_sum;
    logic              bytes_eq;
    logic              hit;
    logic [PROD_W-1:0] prod_new;

    assign in_stall = q_full || pat_info.busy || pat_info.restart;
    assign accept   = in_valid && !in_stall;
    assign push     = accept;

    // Rolling hash: old byte's term is kept premultiplied by -(128^n) mod 1011.
    assign full_now  = (fill_reg >= eff_len);
    assign tail_idx  = IW'(eff_len - LW'(1));
    assign drop      = full_now ? prod_reg[tail_idx] : '0;
    assign hash_sum  = SUM_W'({hash_reg, {RADIX_SH{1'b0}}}) + SUM_W'(text_byte) + SUM_W'(drop);
    assign hash_next = hash_reduce(hash_sum);
    assign fill_next = (fill_reg < LW'(PATTERN_MAX)) ? (fill_reg + 1'b1) : fill_reg;
    assign prod_new  = PROD_W'(text_byte) * PROD_W'(pat_info.qfac);

    // Window after this byte is shifted in.
    always_comb
    begin
        window_new[0] = text_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            window_new[j] = window_reg[j-1];
        end
    end

    // Byte-by-byte compare over the active taps.
    always_comb
    begin
        bytes_eq = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((LW'(j) < eff_len) && (window_new[j] != aligned_pat[j]))
            begin
                bytes_eq = 1'b0;
            end
        end
    end

    // Classification of this request.
    assign hit = (fill_next >= eff_len) && (hash_next == pat_info.hash) && bytes_eq;
    assign push_entry.found = hit;
    assign push_entry.start = hit ? (pos_reg - 32'(eff_len) + 32'd1) : 32'd0;
    assign push_entry.done  = end_of_text;

    // Text state; end of text or a register write starts a new text.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            hash_reg <= '0;
        end
        else if (pat_info.restart)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            hash_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                fill_reg <= '0;
                pos_reg  <= '0;
                hash_reg <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
                pos_reg  <= pos_reg + 32'd1;
                hash_reg <= hash_next;
            end
        end
    end

    // Window and product shift lines; entries beyond the fill count are unused.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                window_reg[j] <= window_new[j];
            end
            prod_reg[0] <= prod_new;
            for (int j = 1; j < PATTERN_MAX; j++)
            begin
                prod_reg[j] <= prod_reg[j-1];
            end
        end
    end

endmodule

>>> sv/rhpm_queue.sv
// ----------------------------------------------------------------------------
// rhpm_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module rhpm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rhpm_pkg::rhpm_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output rhpm_pkg::rhpm_entry_t head_entry
);
    import rhpm_pkg::*;

    rhpm_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops in the same cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/rhpm_back.sv
// ----------------------------------------------------------------------------
// rhpm_back
// Counts matches with saturation and holds each result in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module rhpm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic                  head_valid,
    input  rhpm_pkg::rhpm_entry_t head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  match_found,
    output logic [31:0]           match_start,
    output logic [31:0]           total_matches,
    output logic                  text_done
);
    import rhpm_pkg::*;

    logic        out_valid_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic        found_reg;
    logic [31:0] start_reg;
    logic [31:0] total_reg;
    logic        done_reg;

    // Take the head request when the output register is free or being emptied.
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Saturating match count including the head request.
    assign count_next = (head_entry.found && (count_reg != '1)) ? (count_reg + 32'd1) : count_reg;

    // Control: output valid and the running count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (restart)
            begin
                count_reg <= '0;
            end
            else if (pop)
            begin
                count_reg <= head_entry.done ? 32'd0 : count_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg <= head_entry.found;
            start_reg <= head_entry.start;
            total_reg <= count_next;
            done_reg  <= head_entry.done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_found   = found_reg;
    assign match_start   = start_reg;
    assign total_matches = total_reg;
    assign text_done     = done_reg;

endmodule
